>>> rtl/core/html_named_entity_decoder_core_macros.svh
// Assertion macros for the named entity decoder core.
`ifndef HTML_NAMED_ENTITY_DECODER_CORE_MACROS_SVH
`define HTML_NAMED_ENTITY_DECODER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled in reset.
`define HNED_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hned assertion failed");
// Next-cycle implication, disabled in reset.
`define HNED_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hned assertion failed");
`else
`define HNED_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define HNED_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/hned_pkg.sv
// Shared types, entity table and helper functions for the entity decoder.
`default_nettype none
package hned_pkg;

   localparam int ENT_COUNT = 253;
   localparam int NAME_MAX_LEN = 8;
   localparam int POS_W = 4;
   localparam int STEP_W = 4;
   localparam logic [7:0] CHAR_AMP = 8'h26;
   localparam logic [7:0] CHAR_SEMI = 8'h3B;

   // Input and output beats.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       text_end;
   } rsp_type;

   // What follows an optional literal flush.
   typedef enum logic [1:0] {
      TAIL_NONE,
      TAIL_BYTE,
      TAIL_CP
   } tail_kind_type;

   // One command from the classifier to the output sequencer.
   typedef struct packed {
      logic                 append;
      logic [POS_W-1:0]     app_pos;
      logic [7:0]           app_byte;
      logic                 flush;
      logic [POS_W-1:0]     flush_len;
      tail_kind_type        tail_kind;
      logic [15:0]          tail_val;
      logic                 last;
   } cmd_type;

   // Queue status seen by the classifier.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   localparam logic [63:0] ENT_NAME [ENT_COUNT] = '{
      "AElig","Aacute","Acirc","Agrave","Alpha",
      "Aring","Atilde","Auml","Beta","Ccedil",
      "Chi","Dagger","Delta","ETH","Eacute",
      "Ecirc","Egrave","Epsilon","Eta","Euml",
      "Gamma","Iacute","Icirc","Igrave","Iota",
      "Iuml","Kappa","Lambda","Mu","Ntilde",
      "Nu","OElig","Oacute","Ocirc","Ograve",
      "Omega","Omicron","Oslash","Otilde","Ouml",
      "Phi","Pi","Prime","Psi","Rho",
      "Scaron","Sigma","THORN","Tau","Theta",
      "Uacute","Ucirc","Ugrave","Upsilon","Uuml",
      "Xi","Yacute","Yuml","Zeta",
      "aacute","acirc","acute","aelig","agrave",
      "alefsym","alpha","amp","and","ang",
      "apos","aring","asymp","atilde","auml",
      "bdquo","beta","brvbar","bull","cap",
      "ccedil","cedil","cent","chi","circ",
      "clubs","cong","copy","crarr","cup",
      "curren","dArr","dagger","darr","deg",
      "delta","diams","divide","eacute","ecirc",
      "egrave","empty","emsp","ensp","epsilon",
      "equiv","eta","eth","euml","euro",
      "exist","fnof","forall","frac12","frac14",
      "frac34","frasl","gamma","ge","gt",
      "hArr","harr","hearts","hellip","iacute",
      "icirc","iexcl","igrave","image","infin",
      "int","iota","iquest","isin","iuml",
      "kappa","lArr","lambda","lang","laquo",
      "larr","lceil","ldquo","le","lfloor",
      "lowast","loz","lrm","lsaquo","lsquo",
      "lt","macr","mdash","micro","middot",
      "minus","mu","nabla","nbsp","ndash",
      "ne","ni","not","notin","nsub",
      "ntilde","nu","oacute","ocirc","oelig",
      "ograve","oline","omega","omicron","oplus",
      "or","ordf","ordm","oslash","otilde",
      "otimes","ouml","para","part","permil",
      "perp","phi","pi","piv","plusmn",
      "pound","prime","prod","prop","psi",
      "quot","rArr","radic","rang","raquo",
      "rarr","rceil","rdquo","real","reg",
      "rfloor","rho","rlm","rsaquo","rsquo",
      "sbquo","scaron","sdot","sect","shy",
      "sigma","sigmaf","sim","spades","sub",
      "sube","sum","sup1","sup2","sup3",
      "sup","supe","szlig","tau","there4",
      "theta","thetasym","thinsp","thorn","tilde",
      "times","trade","uArr","uacute","uarr",
      "ucirc","ugrave","uml","upsih","upsilon",
      "uuml","weierp","xi","yacute","yen",
      "yuml","zeta","zwj","zwnj"
   };

   localparam logic [15:0] ENT_CP [ENT_COUNT] = '{
      16'd198,16'd193,16'd194,16'd192,16'd913,
      16'd197,16'd195,16'd196,16'd914,16'd199,
      16'd935,16'd8225,16'd916,16'd208,16'd201,
      16'd202,16'd200,16'd917,16'd919,16'd203,
      16'd915,16'd205,16'd206,16'd204,16'd921,
      16'd207,16'd922,16'd923,16'd924,16'd209,
      16'd925,16'd338,16'd211,16'd212,16'd210,
      16'd937,16'd927,16'd216,16'd213,16'd214,
      16'd934,16'd928,16'd8243,16'd936,16'd929,
      16'd352,16'd931,16'd222,16'd932,16'd920,
      16'd218,16'd219,16'd217,16'd933,16'd220,
      16'd926,16'd221,16'd376,16'd918,
      16'd225,16'd226,16'd180,16'd230,16'd224,
      16'd8501,16'd945,16'd38,16'd8743,16'd8736,
      16'd39,16'd229,16'd8776,16'd227,16'd228,
      16'd8222,16'd946,16'd166,16'd8226,16'd8745,
      16'd231,16'd184,16'd162,16'd967,16'd710,
      16'd9827,16'd8773,16'd169,16'd8629,16'd8746,
      16'd164,16'd8659,16'd8224,16'd8595,16'd176,
      16'd948,16'd9830,16'd247,16'd233,16'd234,
      16'd232,16'd8709,16'd8195,16'd8194,16'd949,
      16'd8801,16'd951,16'd240,16'd235,16'd8364,
      16'd8707,16'd402,16'd8704,16'd189,16'd188,
      16'd190,16'd8260,16'd947,16'd8805,16'd62,
      16'd8660,16'd8596,16'd9829,16'd8230,16'd237,
      16'd238,16'd161,16'd236,16'd8465,16'd8734,
      16'd8747,16'd953,16'd191,16'd8712,16'd239,
      16'd954,16'd8656,16'd955,16'd9001,16'd171,
      16'd8592,16'd8968,16'd8220,16'd8804,16'd8970,
      16'd8727,16'd9674,16'd8206,16'd8249,16'd8216,
      16'd60,16'd175,16'd8212,16'd181,16'd183,
      16'd8722,16'd956,16'd8711,16'd160,16'd8211,
      16'd8800,16'd8715,16'd172,16'd8713,16'd8836,
      16'd241,16'd957,16'd243,16'd244,16'd339,
      16'd242,16'd8254,16'd969,16'd959,16'd8853,
      16'd8744,16'd170,16'd186,16'd248,16'd245,
      16'd8855,16'd246,16'd182,16'd8706,16'd8240,
      16'd8869,16'd966,16'd960,16'd982,16'd177,
      16'd163,16'd8242,16'd8719,16'd8733,16'd968,
      16'd34,16'd8658,16'd8730,16'd9002,16'd187,
      16'd8594,16'd8969,16'd8221,16'd8476,16'd174,
      16'd8971,16'd961,16'd8207,16'd8250,16'd8217,
      16'd8218,16'd353,16'd8901,16'd167,16'd173,
      16'd963,16'd962,16'd8764,16'd9824,16'd8834,
      16'd8838,16'd8721,16'd185,16'd178,16'd179,
      16'd8835,16'd8839,16'd223,16'd964,16'd8756,
      16'd952,16'd977,16'd8201,16'd254,16'd732,
      16'd215,16'd8482,16'd8657,16'd250,16'd8593,
      16'd251,16'd249,16'd168,16'd978,16'd965,
      16'd252,16'd8472,16'd958,16'd253,16'd165,
      16'd255,16'd950,16'd8205,16'd8204
   };

   // Number of characters in a table name.
   function automatic logic [POS_W-1:0] ent_len(input int k);
      logic [POS_W-1:0] n;
      n = '0;
      for (int i = 0; i < NAME_MAX_LEN; i++) begin
         if (ENT_NAME[k][i*8 +: 8] != 8'h00) begin
            n = n + 1'b1;
         end
      end
      return n;
   endfunction

   // Character at position p of a table name; zero past its end.
   function automatic logic [7:0] ent_char(input int k, input logic [2:0] p);
      logic [7:0] ch;
      int         len;
      ch = 8'h00;
      len = int'(ent_len(k));
      for (int i = 0; i < NAME_MAX_LEN; i++) begin
         if (i == len - 1 - int'(p)) begin
            ch = ENT_NAME[k][i*8 +: 8];
         end
      end
      return ch;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/hned_front.sv
// Classifier: tracks the open entity match and turns input beats into commands.
`default_nettype none
module hned_front #(
   parameter int PREFIX_DEPTH = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire hned_pkg::req_type      req_data,
   input  wire hned_pkg::q_status_type q_status,
   output logic                        push,
   output hned_pkg::cmd_type           cmd
);

   logic                              in_entity_ff, in_entity_in;
   logic [hned_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [hned_pkg::ENT_COUNT-1:0]    mask_ff, mask_in;
   logic [hned_pkg::ENT_COUNT-1:0]    hit;
   logic [hned_pkg::ENT_COUNT-1:0]    comp;
   logic [15:0]                       found_cp;
   logic                              accept;
   logic                              extend;
   logic                              complete;
   logic [7:0]                        b;
   logic                              last;
   logic                              fresh;
   hned_pkg::cmd_type                 cmd_c;

   assign accept = req_valid && !q_status.full;
   assign b      = req_data.in_byte;
   assign last   = req_data.in_last;

   // Candidate names that the next byte keeps alive, and the name that is complete now.
   always_comb begin
      found_cp = '0;
      for (int k = 0; k < hned_pkg::ENT_COUNT; k++) begin
         hit[k]  = mask_ff[k] && (hned_pkg::ent_len(k) > pos_ff) &&
                   (hned_pkg::ent_char(k, pos_ff[2:0]) == b);
         comp[k] = mask_ff[k] && (hned_pkg::ent_len(k) == pos_ff);
         found_cp = found_cp | (comp[k] ? hned_pkg::ENT_CP[k] : 16'h0000);
      end
   end

   assign complete = (b == hned_pkg::CHAR_SEMI) && (|comp);
   assign extend   = (b != hned_pkg::CHAR_SEMI) && (32'(pos_ff) < PREFIX_DEPTH) && (|hit);

   // Classify the beat into flush, append and tail actions.
   always_comb begin
      cmd_c           = '0;
      cmd_c.tail_kind = hned_pkg::TAIL_NONE;
      cmd_c.app_byte  = b;
      cmd_c.app_pos   = pos_ff;
      cmd_c.tail_val  = {8'h00, b};
      cmd_c.last      = last;
      in_entity_in    = in_entity_ff;
      pos_in          = pos_ff;
      mask_in         = mask_ff;
      fresh           = 1'b0;
      if (in_entity_ff) begin
         if (complete) begin
            cmd_c.tail_kind = hned_pkg::TAIL_CP;
            cmd_c.tail_val  = found_cp;
            in_entity_in    = 1'b0;
            pos_in          = '0;
         end else if (extend) begin
            cmd_c.append = 1'b1;
            mask_in      = hit;
            pos_in       = pos_ff + 1'b1;
            if (last) begin
               cmd_c.flush     = 1'b1;
               cmd_c.flush_len = pos_ff + 1'b1;
               in_entity_in    = 1'b0;
               pos_in          = '0;
            end
         end else begin
            cmd_c.flush     = 1'b1;
            cmd_c.flush_len = pos_ff;
            in_entity_in    = 1'b0;
            pos_in          = '0;
            fresh           = 1'b1;
         end
      end else begin
         fresh = 1'b1;
      end
      // A fresh ampersand opens a match; at the end of text it flushes as itself.
      if (fresh) begin
         if (b == hned_pkg::CHAR_AMP && !last) begin
            in_entity_in = 1'b1;
            pos_in       = '0;
            mask_in      = '1;
         end else begin
            cmd_c.tail_kind = hned_pkg::TAIL_BYTE;
         end
      end
   end

   assign cmd  = cmd_c;
   assign push = accept &&
                 (cmd_c.append || cmd_c.flush || cmd_c.tail_kind != hned_pkg::TAIL_NONE);

   // Match state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_entity_ff <= 1'b0;
         pos_ff       <= '0;
      end else if (accept) begin
         in_entity_ff <= in_entity_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mask_ff <= mask_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/hned_queue.sv
// Two-entry command queue between the classifier and the output sequencer.
`default_nettype none
module hned_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire hned_pkg::cmd_type      push_cmd,
   input  wire logic                   pop,
   output hned_pkg::cmd_type           head_cmd,
   output hned_pkg::q_status_type      status
);

   hned_pkg::cmd_type slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   // Pointer and fill bookkeeping.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd     = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

endmodule
`default_nettype wire

>>> rtl/core/hned_back.sv
// Output sequencer: keeps the name buffer and emits one output byte per cycle while the output is not stalled.
`default_nettype none
module hned_back #(
   parameter int PREFIX_DEPTH = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire hned_pkg::cmd_type      head_cmd,
   input  wire hned_pkg::q_status_type q_status,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output hned_pkg::rsp_type           rsp_data
);

   localparam int IDX_W = $clog2(PREFIX_DEPTH);

   logic [7:0]                   name_ff [PREFIX_DEPTH];
   hned_pkg::cmd_type            cmd_ff, cmd_in;
   logic                         cmd_valid_ff, cmd_valid_in;
   logic [hned_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   hned_pkg::rsp_type            rsp_ff, rsp_in;
   logic [hned_pkg::STEP_W-1:0]  flush_cnt;
   logic [hned_pkg::STEP_W-1:0]  tail_cnt;
   logic [hned_pkg::STEP_W-1:0]  total;
   logic [hned_pkg::STEP_W-1:0]  tail_step;
   logic [7:0]                   tail_byte [3];
   logic [7:0]                   cur_byte;
   logic                         is_final;
   logic                         out_free;
   logic                         emit;
   logic                         finish;
   logic                         head_outputs;
   logic [15:0]                  cp;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Byte counts of the current command and its UTF-8 tail.
   always_comb begin
      cp           = cmd_ff.tail_val;
      tail_byte[0] = cp[7:0];
      tail_byte[1] = 8'h00;
      tail_byte[2] = 8'h00;
      tail_cnt     = '0;
      case (cmd_ff.tail_kind)
         hned_pkg::TAIL_BYTE: begin
            tail_cnt = 4'd1;
         end
         hned_pkg::TAIL_CP: begin
            if (cp < 16'h0080) begin
               tail_cnt = 4'd1;
            end else if (cp < 16'h0800) begin
               tail_cnt     = 4'd2;
               tail_byte[0] = {3'b110, cp[10:6]};
               tail_byte[1] = {2'b10, cp[5:0]};
            end else begin
               tail_cnt     = 4'd3;
               tail_byte[0] = {4'b1110, cp[15:12]};
               tail_byte[1] = {2'b10, cp[11:6]};
               tail_byte[2] = {2'b10, cp[5:0]};
            end
         end
         default: begin
            tail_cnt = '0;
         end
      endcase
      flush_cnt = cmd_ff.flush ? (cmd_ff.flush_len + 1'b1) : '0;
      total     = flush_cnt + tail_cnt;
      is_final  = (step_ff == total - 1'b1);
   end

   // Select the byte for the current step: ampersand, buffered name, then tail.
   always_comb begin
      tail_step = step_ff - flush_cnt;
      if (step_ff < flush_cnt) begin
         if (step_ff == '0) begin
            cur_byte = hned_pkg::CHAR_AMP;
         end else begin
            cur_byte = name_ff[IDX_W'(step_ff - 1'b1)];
         end
      end else begin
         cur_byte = tail_byte[tail_step[1:0] == 2'd3 ? 2'd2 : tail_step[1:0]];
      end
   end

   assign emit         = cmd_valid_ff && out_free;
   assign finish       = emit && is_final;
   assign pop          = !q_status.empty && (!cmd_valid_ff || finish);
   assign head_outputs = head_cmd.flush || (head_cmd.tail_kind != hned_pkg::TAIL_NONE);

   // Command register and step counter.
   always_comb begin
      cmd_in       = cmd_ff;
      cmd_valid_in = cmd_valid_ff;
      step_in      = step_ff;
      if (pop) begin
         cmd_in       = head_cmd;
         cmd_valid_in = head_outputs;
         step_in      = '0;
      end else if (finish) begin
         cmd_valid_in = 1'b0;
      end else if (emit) begin
         step_in = step_ff + 1'b1;
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in    = 1'b1;
         rsp_in.out_byte = cur_byte;
         rsp_in.run_last = is_final;
         rsp_in.text_end = is_final && cmd_ff.last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      step_ff <= step_in;
      rsp_ff  <= rsp_in;
   end

   // Name buffer: a popped append command stores its byte.
   always_ff @(posedge clock) begin
      if (pop && head_cmd.append) begin
         name_ff[IDX_W'(head_cmd.app_pos)] <= head_cmd.app_byte;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

>>> rtl/core/html_named_entity_decoder_core.sv
// Top level of the HTML named entity decoder core.
// Decodes HTML 4 named character references (plus apos) in a byte stream to UTF-8.
// One input byte is taken per cycle as long as the two-entry command queue has room;
// the output side emits one byte per cycle while rsp_stall is low, so an input beat
// that yields n bytes (0 to 10: a literal flush of '&' and up to eight name bytes,
// plus a tail of up to three bytes) holds the output sequencer until all n are out;
// a beat that only extends a pending name just stores its byte in the name buffer.
// A byte passes the queue slot, command register and output register on its way out.
// Candidate names are one bit per table entry, updated by the classifier as it takes a byte.
`default_nettype none
`include "html_named_entity_decoder_core_macros.svh"
module html_named_entity_decoder_core #(
   parameter int PREFIX_DEPTH = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire hned_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output hned_pkg::rsp_type      rsp_data
);

   logic                   q_push;
   logic                   q_pop;
   hned_pkg::cmd_type      push_cmd;
   hned_pkg::cmd_type      head_cmd;
   hned_pkg::q_status_type q_status;

   assign req_stall = q_status.full;

   // Classifier.
   hned_front #(
      .PREFIX_DEPTH(PREFIX_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_data (req_data),
      .q_status (q_status),
      .push     (q_push),
      .cmd      (push_cmd)
   );

   // Command queue.
   hned_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_cmd(push_cmd),
      .pop     (q_pop),
      .head_cmd(head_cmd),
      .status  (q_status)
   );

   // Output sequencer.
   hned_back #(
      .PREFIX_DEPTH(PREFIX_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head_cmd (head_cmd),
      .q_status (q_status),
      .pop      (q_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // The queue never takes a command while full, and never gives one while empty.
   `HNED_ASSERT_IMPLY(a_no_push_full, clock, reset, q_push, !q_status.full)
   `HNED_ASSERT_IMPLY(a_no_pop_empty, clock, reset, q_pop, !q_status.empty)
   // End of text only sits on the last byte of a run.
   `HNED_ASSERT_IMPLY(a_end_is_run_last, clock, reset, rsp_valid && rsp_data.text_end,
      rsp_data.run_last)

endmodule
`default_nettype wire
